// ----- design/tmsrc_pkg.sv -----
// Shared types and constants for the tile map store with region count.
// Used by tmsrc_clamp and tile_map_store_region_count; depends on nothing.
package tmsrc_pkg;

  // Default storage geometry.
  localparam int MAX_COLS_DEF  = 32;
  localparam int MAX_ROWS_DEF  = 32;
  localparam int TILE_BITS_DEF = 8;

  // Fixed field widths.
  localparam int COORD_W = 11;  // signed tile coordinates
  localparam int DIM_W   = 6;   // map size registers and clamped coordinates
  localparam int VAL_W   = 8;   // write_value / match_value
  localparam int RD_W    = 9;   // read_value
  localparam int CNT_W   = 11;  // match_count
  localparam int CFG_IDX_W = 1;

  typedef enum logic [1:0] {
    REQ_READ  = 2'd0,
    REQ_WRITE = 2'd1,
    REQ_COUNT = 2'd2,
    REQ_NONE  = 2'd3
  } req_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAP_WIDTH  = 1'b0,
    CFG_MAP_HEIGHT = 1'b1
  } cfg_idx_t;

  // Request geometry after bounds check and rectangle clamping.
  typedef struct packed {
    logic             on_map;  // col/row point lies inside the map
    logic [DIM_W-1:0] col_ix;  // col, valid when on_map
    logic [DIM_W-1:0] row_ix;  // row, valid when on_map
    logic [DIM_W-1:0] top;
    logic [DIM_W-1:0] bot;
    logic [DIM_W-1:0] left;
    logic [DIM_W-1:0] right;
  } geom_t;

endpackage

// ----- design/tmsrc_clamp.sv -----
// Bounds check and rectangle normalize/clamp for one request.
// Depends on tmsrc_pkg.
module tmsrc_clamp (
  input  logic signed [tmsrc_pkg::COORD_W-1:0] col,
  input  logic signed [tmsrc_pkg::COORD_W-1:0] row,
  input  logic signed [tmsrc_pkg::COORD_W-1:0] col_end,
  input  logic signed [tmsrc_pkg::COORD_W-1:0] row_end,
  input  logic        [tmsrc_pkg::DIM_W-1:0]   dim_w,
  input  logic        [tmsrc_pkg::DIM_W-1:0]   dim_h,
  output tmsrc_pkg::geom_t                     geom
);
  import tmsrc_pkg::*;

  logic signed [COORD_W-1:0] w_s;
  logic signed [COORD_W-1:0] h_s;
  logic signed [COORD_W-1:0] top_p;
  logic signed [COORD_W-1:0] left_p;

  function automatic logic [DIM_W-1:0] clamp_edge(input logic signed [COORD_W-1:0] v,
                                                  input logic signed [COORD_W-1:0] lim);
    logic [DIM_W-1:0] r;
    if (v < 0) begin
      r = '0;
    end else if (v >= lim) begin
      r = DIM_W'(lim - COORD_W'(1));
    end else begin
      r = v[DIM_W-1:0];
    end
    return r;
  endfunction

  always_comb begin
    w_s    = $signed({{(COORD_W-DIM_W){1'b0}}, dim_w});
    h_s    = $signed({{(COORD_W-DIM_W){1'b0}}, dim_h});
    // top/left pulled down onto bottom/right when the rectangle is flipped
    top_p  = (row > row_end) ? row_end : row;
    left_p = (col > col_end) ? col_end : col;

    geom.on_map = (col >= 0) && (row >= 0) && (col < w_s) && (row < h_s);
    geom.col_ix = col[DIM_W-1:0];
    geom.row_ix = row[DIM_W-1:0];
    geom.top    = clamp_edge(top_p, h_s);
    geom.bot    = clamp_edge(row_end, h_s);
    geom.left   = clamp_edge(left_p, w_s);
    geom.right  = clamp_edge(col_end, w_s);
  end

endmodule

// ----- design/tile_map_store_region_count.sv -----
// Top level of the tile map store: request sequencer, tile memory, result register.
// Depends on tmsrc_pkg and tmsrc_clamp.

// Tile map store with read, write and region count. The map lives row-major in a
// single-port memory of MAX_COLS*MAX_ROWS tiles; tile (col,row) sits at
// col + row*map_width, with map_width/map_height limited to 1..MAX_COLS/MAX_ROWS.
// Memory contents are undefined until written, so load the map before reading it.
// Flow: a read, a write or an unknown request moves to the finish state at the
// transfer, where its result is formed and loaded into the output register. For a
// region count the sequencer first walks the clamped rectangle one tile per cycle
// through the single memory read port and one shared row*width+col address unit,
// comparing the returned tile in the following cycle. in_ready is high only while
// the sequencer is idle. A finished result sits in the output register; the next
// request can be taken while it waits, and only the next finish stalls on it.
// Configuration writes are always taken (cfg_ready tied high) and must only be
// issued while no request is active.
module tile_map_store_region_count #(
  parameter int MAX_COLS  = tmsrc_pkg::MAX_COLS_DEF,
  parameter int MAX_ROWS  = tmsrc_pkg::MAX_ROWS_DEF,
  parameter int TILE_BITS = tmsrc_pkg::TILE_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // configuration write channel
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [tmsrc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [tmsrc_pkg::DIM_W-1:0]           cfg_data,
  // request channel
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic [1:0]                            req_type,
  input  logic signed [tmsrc_pkg::COORD_W-1:0]  col,
  input  logic signed [tmsrc_pkg::COORD_W-1:0]  row,
  input  logic signed [tmsrc_pkg::COORD_W-1:0]  col_end,
  input  logic signed [tmsrc_pkg::COORD_W-1:0]  row_end,
  input  logic [tmsrc_pkg::VAL_W-1:0]           write_value,
  input  logic [tmsrc_pkg::VAL_W-1:0]           match_value,
  // result channel
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [tmsrc_pkg::RD_W-1:0]     read_value,
  output logic                                  occupied,
  output logic [tmsrc_pkg::CNT_W-1:0]           match_count,
  output logic                                  status
);
  import tmsrc_pkg::*;

  localparam int DEPTH   = MAX_COLS * MAX_ROWS;
  localparam int AW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int DIM_MAX = (1 << DIM_W) - 1;
  localparam int COL_LIM = (MAX_COLS < DIM_MAX) ? MAX_COLS : DIM_MAX;
  localparam int ROW_LIM = (MAX_ROWS < DIM_MAX) ? MAX_ROWS : DIM_MAX;
  localparam int IX_W    = 2 * DIM_W;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_FIN  = 3'b100
  } state_t;

  // ---------------------------------------------------------------------------
  // Configuration registers; effective map size clamped into range
  // ---------------------------------------------------------------------------
  logic [DIM_W-1:0] map_width;
  logic [DIM_W-1:0] map_height;
  logic [DIM_W-1:0] w_eff;
  logic [DIM_W-1:0] h_eff;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      map_width  <= DIM_W'(32);
      map_height <= DIM_W'(32);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_MAP_WIDTH:  map_width  <= cfg_data;
        CFG_MAP_HEIGHT: map_height <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (map_width == '0) begin
      w_eff = DIM_W'(1);
    end else if (map_width > DIM_W'(COL_LIM)) begin
      w_eff = DIM_W'(COL_LIM);
    end else begin
      w_eff = map_width;
    end
    if (map_height == '0) begin
      h_eff = DIM_W'(1);
    end else if (map_height > DIM_W'(ROW_LIM)) begin
      h_eff = DIM_W'(ROW_LIM);
    end else begin
      h_eff = map_height;
    end
  end

  // ---------------------------------------------------------------------------
  // Request geometry
  // ---------------------------------------------------------------------------
  geom_t geom;
  geom_t geom_q;

  tmsrc_clamp u_clamp (
    .col     (col),
    .row     (row),
    .col_end (col_end),
    .row_end (row_end),
    .dim_w   (w_eff),
    .dim_h   (h_eff),
    .geom    (geom)
  );

  // ---------------------------------------------------------------------------
  // Sequencer state
  // ---------------------------------------------------------------------------
  state_t             state;
  state_t             state_next;
  req_t               req_q;
  logic [VAL_W-1:0]   match_q;
  logic [DIM_W-1:0]   x_q;
  logic [DIM_W-1:0]   y_q;
  logic               pend_q;    // memory data from a scan read arrives this cycle
  logic [CNT_W-1:0]   cnt_q;
  logic               in_xfer;
  logic               out_load;
  logic               row_last;
  logic               scan_last;

  assign in_ready  = (state == ST_IDLE);
  assign in_xfer   = in_valid && in_ready;
  assign out_load  = (state == ST_FIN) && (!out_valid || out_ready);
  assign row_last  = (x_q == geom_q.right);
  assign scan_last = row_last && (y_q == geom_q.bot);

  // ---------------------------------------------------------------------------
  // Shared address unit and tile memory
  // ---------------------------------------------------------------------------
  logic [DIM_W-1:0]     ax;
  logic [DIM_W-1:0]     ay;
  logic [IX_W-1:0]      idx_full;
  logic [AW-1:0]        addr;
  logic                 mem_we;
  logic                 mem_re;
  logic [TILE_BITS-1:0] mem [DEPTH];
  logic [TILE_BITS-1:0] mem_q;
  logic [31:0]          tile_ext;
  logic                 hit;

  always_comb begin
    if (state == ST_SCAN) begin
      ax = x_q;
      ay = y_q;
    end else begin
      ax = geom.col_ix;
      ay = geom.row_ix;
    end
    idx_full = IX_W'(ay) * IX_W'(w_eff) + IX_W'(ax);
  end

  // Coordinates used for a memory access (on-map reads and writes, scan steps) are
  // always inside the map, so the index is below width*height and fits the store.
  assign addr   = AW'(idx_full);
  assign mem_we = in_xfer && (req_t'(req_type) == REQ_WRITE) && geom.on_map;
  assign mem_re = (in_xfer && (req_t'(req_type) == REQ_READ) && geom.on_map)
                  || (state == ST_SCAN);

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[addr] <= TILE_BITS'(write_value);
    end
    if (mem_re) begin
      mem_q <= mem[addr];
    end
  end

  assign tile_ext = 32'(mem_q);
  assign hit      = (tile_ext == 32'(match_q));

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_xfer) begin
          state_next = (req_t'(req_type) == REQ_COUNT) ? ST_SCAN : ST_FIN;
        end
      end
      ST_SCAN: begin
        if (scan_last) begin
          state_next = ST_FIN;
        end
      end
      ST_FIN: begin
        if (out_load) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      pend_q <= 1'b0;
    end else begin
      state  <= state_next;
      pend_q <= (state == ST_SCAN);
    end
  end

  // request context and walk counters
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      req_q   <= req_t'(req_type);
      match_q <= match_value;
      geom_q  <= geom;
      x_q     <= geom.left;
      y_q     <= geom.top;
      cnt_q   <= '0;
    end else begin
      if (state == ST_SCAN) begin
        if (row_last) begin
          x_q <= geom_q.left;
          y_q <= y_q + DIM_W'(1);
        end else begin
          x_q <= x_q + DIM_W'(1);
        end
      end
      if (pend_q && hit) begin
        cnt_q <= cnt_q + CNT_W'(1);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Result forming and output register
  // ---------------------------------------------------------------------------
  logic signed [RD_W-1:0] res_rd;
  logic                   res_occ;
  logic [CNT_W-1:0]       res_cnt;
  logic                   res_st;

  always_comb begin
    res_rd  = '0;
    res_occ = 1'b0;
    res_cnt = '0;
    res_st  = 1'b0;
    unique case (req_q)
      REQ_READ: begin
        if (geom_q.on_map) begin
          res_rd  = $signed(tile_ext[RD_W-1:0]);
          res_occ = (mem_q != '0);
        end else begin
          res_rd  = -RD_W'(1);
          res_occ = 1'b1;
        end
      end
      REQ_WRITE: res_st = !geom_q.on_map;
      REQ_COUNT: res_cnt = cnt_q + CNT_W'(pend_q && hit);
      REQ_NONE:  ;
      default:   ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      read_value  <= res_rd;
      occupied    <= res_occ;
      match_count <= res_cnt;
      status      <= res_st;
    end
  end

`ifndef SYNTH
  // walk stays inside the clamped rectangle
  a_scan_in_rect: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (x_q >= geom_q.left) && (x_q <= geom_q.right)
                           && (y_q >= geom_q.top) && (y_q <= geom_q.bot))
    else $error("scan coordinates left the rectangle");

  // memory is written only on a request transfer
  a_write_on_xfer: assert property (@(posedge clk) disable iff (rst)
    mem_we |-> (state == ST_IDLE) && in_valid)
    else $error("tile write outside a request transfer");

  // a scan compare always follows a scan read
  a_pend_after_scan: assert property (@(posedge clk) disable iff (rst)
    pend_q |-> $past(state == ST_SCAN))
    else $error("compare without scan read");

  // finishing loads the result and frees the sequencer
  a_fin_to_idle: assert property (@(posedge clk) disable iff (rst)
    out_load |=> out_valid && (state == ST_IDLE))
    else $error("result load did not complete the request");

  // during a scan the count never exceeds bot*width plus the current column
  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (cnt_q <= CNT_W'(IX_W'(geom_q.bot) * IX_W'(w_eff) + IX_W'(x_q))))
    else $error("match count ran ahead of the walk");
`endif

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps
// Self-checking bench for tile_map_store_region_count: a directed request table, then
// random traffic over several map sizes, scored against a bench model or typed answers.
// Depends on tmsrc_pkg and the design sources; reads no files.
module testbench;
  import tmsrc_pkg::*;

  localparam int STORE_N     = MAX_COLS_DEF * MAX_ROWS_DEF;
  // Slowest legal run: ~560 requests, each a full-map count (<= 160 tiles here)
  // plus the largest idle gap on both sides, plus one long hold-off; taken several times over.
  localparam int CYCLE_LIMIT = 700000;
  localparam int TAIL_CYCLES = 16;   // idle tail after the last result
  localparam int HOLD_CYCLES = 300;  // long result stall, fills the block up
  localparam int NUM_PHASES  = 6;
  localparam int PHASE_ITEMS = 64;

  // One request as it crosses the input channel.
  typedef struct {
    req_t                      kind;
    logic signed [COORD_W-1:0] col;
    logic signed [COORD_W-1:0] row;
    logic signed [COORD_W-1:0] col_end;
    logic signed [COORD_W-1:0] row_end;
    logic [VAL_W-1:0]          wr_val;
    logic [VAL_W-1:0]          match_val;
  } tile_req_t;

  // One response as it crosses the output channel.
  typedef struct {
    logic signed [RD_W-1:0] rd;
    logic                   occ;
    logic [CNT_W-1:0]       cnt;
    logic                   st;
  } tile_resp_t;

  // Row of the directed table: typed rows carry a hand-written response.
  typedef struct {
    tile_req_t  rq;
    bit         typed;
    tile_resp_t want;
  } dir_step_t;

  // ---------------------------------------------------------------------------
  // DUT signals; every input starts at a known value
  // ---------------------------------------------------------------------------
  logic                      clk         = 1'b0;
  logic                      rst         = 1'b1;
  logic                      cfg_valid   = 1'b0;
  logic                      cfg_ready;
  logic [CFG_IDX_W-1:0]      cfg_index   = CFG_MAP_WIDTH;
  logic [DIM_W-1:0]          cfg_data    = '0;
  logic                      in_valid    = 1'b0;
  logic                      in_ready;
  logic [1:0]                req_type    = REQ_READ;
  logic signed [COORD_W-1:0] col         = '0;
  logic signed [COORD_W-1:0] row         = '0;
  logic signed [COORD_W-1:0] col_end     = '0;
  logic signed [COORD_W-1:0] row_end     = '0;
  logic [VAL_W-1:0]          write_value = '0;
  logic [VAL_W-1:0]          match_value = '0;
  logic                      out_valid;
  logic                      out_ready   = 1'b0;
  logic signed [RD_W-1:0]    read_value;
  logic                      occupied;
  logic [CNT_W-1:0]          match_count;
  logic                      status;

  tile_map_store_region_count i_dut (.*);

  // ---------------------------------------------------------------------------
  // Model state: tile contents, which entries hold a known value, size registers
  // ---------------------------------------------------------------------------
  logic [VAL_W-1:0] tile_mem    [STORE_N];
  bit               tile_loaded [STORE_N];
  logic [DIM_W-1:0] map_w_reg = 6'd32;
  logic [DIM_W-1:0] map_h_reg = 6'd32;

  tile_resp_t tile_resp_q [$];  // responses owed by the DUT, oldest first
  dir_step_t  dir_steps   [$];

  int gap_max      = 8;   // idle draw range for both sides; 0 gives back-to-back traffic
  bit hold_off_req = 1'b0;
  int bad_cnt      = 0;
  int cycle_cnt    = 0;

  // Map sizes per random phase, raw register values: 0 and 63 are out of range
  // (used as 1 and 32), and the set reaches both ends of each register.
  logic [DIM_W-1:0] ph_w   [NUM_PHASES] = '{6'd0, 6'd63, 6'd1,  6'd32, 6'd7, 6'd13};
  logic [DIM_W-1:0] ph_h   [NUM_PHASES] = '{6'd0, 6'd1,  6'd63, 6'd3,  6'd5, 6'd12};
  int               ph_gap [NUM_PHASES] = '{8,    0,     8,     8,     8,    0};

  initial begin
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Model
  // ---------------------------------------------------------------------------
  function automatic int used_dim(logic [DIM_W-1:0] v, int most);
    if (v == '0) return 1;
    if (int'(v) > most) return most;
    return int'(v);
  endfunction

  function automatic int clamp_into(int v, int lim);
    if (v < 0) return 0;
    if (v >= lim) return lim - 1;
    return v;
  endfunction

  // Applies one request to the model map and returns the response it owes.
  function automatic tile_resp_t tile_map_apply(tile_req_t rq);
    tile_resp_t rs;
    int         w, h, c, r, ix, top, bot, lft, rgt, y, x;
    bit         on_map;
    w      = used_dim(map_w_reg, MAX_COLS_DEF);
    h      = used_dim(map_h_reg, MAX_ROWS_DEF);
    c      = rq.col;
    r      = rq.row;
    on_map = (c >= 0) && (r >= 0) && (c < w) && (r < h);
    ix     = c + r * w;
    rs.rd  = '0;
    rs.occ = 1'b0;
    rs.cnt = '0;
    rs.st  = 1'b0;
    case (rq.kind)
      REQ_READ: begin
        if (on_map) begin
          rs.rd  = {1'b0, tile_mem[ix]};
          rs.occ = (tile_mem[ix] != '0);
        end else begin
          rs.rd  = '1;  // -1, and it counts as occupied
          rs.occ = 1'b1;
        end
      end
      REQ_WRITE: begin
        if (on_map) begin
          tile_mem[ix]    = rq.wr_val;
          tile_loaded[ix] = 1'b1;
        end else begin
          rs.st = 1'b1;  // dropped, never wrapped into another row
        end
      end
      REQ_COUNT: begin
        // straighten the rectangle first, then pull each edge into the map
        top = r;
        bot = rq.row_end;
        lft = c;
        rgt = rq.col_end;
        if (top > bot) top = bot;
        if (lft > rgt) lft = rgt;
        top = clamp_into(top, h);
        bot = clamp_into(bot, h);
        lft = clamp_into(lft, w);
        rgt = clamp_into(rgt, w);
        for (y = top; y <= bot; y++) begin
          for (x = lft; x <= rgt; x++) begin
            if (tile_mem[x + y * w] == rq.match_val) rs.cnt++;
          end
        end
      end
      default: ;  // unknown request: no effect, all-zero response
    endcase
    return rs;
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  // Mostly a small set of tile values so region counts find matches.
  function automatic logic [VAL_W-1:0] pick_tile_val();
    if ($urandom_range(0, 3) != 0) begin
      case ($urandom_range(0, 3))
        0:       return 8'h00;
        1:       return 8'h01;
        2:       return 8'h02;
        default: return 8'hFF;
      endcase
    end
    return VAL_W'($urandom());
  endfunction

  // Mostly inside the map, some just past either edge, some anywhere.
  function automatic logic signed [COORD_W-1:0] pick_coord(int lim);
    int p;
    p = $urandom_range(0, 9);
    if (p < 7) return COORD_W'($urandom_range(0, lim - 1));
    if (p == 7) return COORD_W'(lim + int'($urandom_range(0, 2)));
    if (p == 8) return COORD_W'(-1 - int'($urandom_range(0, 2)));
    return COORD_W'($urandom());
  endfunction

  task automatic add_step(input req_t k, input int c, input int r, input int ce,
                          input int re, input int wv, input int mv, input bit typed,
                          input int rd, input int occ, input int cnt, input int st);
    dir_step_t s;
    s.rq.kind      = k;
    s.rq.col       = COORD_W'(c);
    s.rq.row       = COORD_W'(r);
    s.rq.col_end   = COORD_W'(ce);
    s.rq.row_end   = COORD_W'(re);
    s.rq.wr_val    = VAL_W'(wv);
    s.rq.match_val = VAL_W'(mv);
    s.typed        = typed;
    s.want.rd      = RD_W'(rd);
    s.want.occ     = occ[0];
    s.want.cnt     = CNT_W'(cnt);
    s.want.st      = st[0];
    dir_steps.insert(dir_steps.size(), s);
  endtask

  task automatic report_mismatch(input string msg);
    $display("%0t ns  mismatch: %s", $time, msg);
    bad_cnt++;
  endtask

  // Offers one request after a random idle gap and books its response once the
  // transfer happens. With drain set, waits for every owed response first.
  task automatic issue_req(input tile_req_t rq, input bit typed, input tile_resp_t want,
                           input bit drain);
    int         gap;
    tile_resp_t pred;
    gap = $urandom_range(0, gap_max);
    // valid only drops when a gap follows, never low-then-high in one step
    if (drain || gap > 0) in_valid <= 1'b0;
    if (drain) begin
      do @(posedge clk); while (tile_resp_q.size() != 0);
    end
    repeat (gap) @(posedge clk);
    in_valid    <= 1'b1;
    req_type    <= rq.kind;
    col         <= rq.col;
    row         <= rq.row;
    col_end     <= rq.col_end;
    row_end     <= rq.row_end;
    write_value <= rq.wr_val;
    match_value <= rq.match_val;
    do @(posedge clk); while (!in_ready);
    pred = tile_map_apply(rq);
    if (typed) begin
      tile_resp_q.insert(tile_resp_q.size(), want);
    end else begin
      tile_resp_q.insert(tile_resp_q.size(), pred);
    end
  endtask

  // Size registers only change with nothing in flight; every request answers,
  // so an empty queue means the sequencer is idle.
  task automatic set_map_size(input logic [DIM_W-1:0] wv, input logic [DIM_W-1:0] hv);
    in_valid <= 1'b0;
    do @(posedge clk); while (tile_resp_q.size() != 0);
    cfg_valid <= 1'b1;
    cfg_index <= CFG_MAP_WIDTH;
    cfg_data  <= wv;
    do @(posedge clk); while (!cfg_ready);
    map_w_reg = wv;
    cfg_index <= CFG_MAP_HEIGHT;
    cfg_data  <= hv;
    do @(posedge clk); while (!cfg_ready);
    map_h_reg = hv;
    cfg_valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Result side: random stalls, plus one long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin : result_sink
    int stall;
    do @(posedge clk); while (rst);
    forever begin
      stall = $urandom_range(0, gap_max);
      if (hold_off_req) begin
        stall        = HOLD_CYCLES;
        hold_off_req = 1'b0;
      end
      if (stall > 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
    end
  end

  // Scoreboard: each result transfer against the oldest owed response.
  always @(posedge clk) begin : result_check
    tile_resp_t want;
    if (!rst && out_valid && out_ready) begin
      if (tile_resp_q.size() == 0) begin
        report_mismatch("result transfer with no request outstanding");
      end else begin
        want = tile_resp_q.pop_front();
        if (read_value !== want.rd)
          report_mismatch($sformatf("read_value %0d, want %0d", read_value, want.rd));
        if (occupied !== want.occ)
          report_mismatch($sformatf("occupied %0b, want %0b", occupied, want.occ));
        if (match_count !== want.cnt)
          report_mismatch($sformatf("match_count %0d, want %0d", match_count, want.cnt));
        if (status !== want.st)
          report_mismatch($sformatf("status %0b, want %0b", status, want.st));
      end
    end
  end

  // Hang guard.
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    tile_req_t  rq;
    tile_resp_t no_resp;
    int         ph, k, ix, w, h, p;
    no_resp.rd  = '0;
    no_resp.occ = 1'b0;
    no_resp.cnt = '0;
    no_resp.st  = 1'b0;

    // Directed table, run at the reset size of 32x32. Only tiles written here
    // are ever read or counted. Typed rows hold the obvious answers.
    //       kind         col    row  c_end  r_end   wr  match typ   rd occ cnt st
    add_step(REQ_WRITE,     0,     0,     0,     0, 255,    0,  1,    0, 0, 0, 0);
    add_step(REQ_WRITE,    31,    31,     0,     0,   0,  255,  1,    0, 0, 0, 0);
    add_step(REQ_WRITE,     1,     0,     0,     0, 255,    0,  1,    0, 0, 0, 0);
    add_step(REQ_WRITE,     2,     0,     0,     0,  90,    0,  1,    0, 0, 0, 0);
    // writes off the map are dropped and flagged
    add_step(REQ_WRITE,    32,     0,     0,     0,   7,    0,  1,    0, 0, 0, 1);
    add_step(REQ_WRITE,     0,    32,     0,     0,   7,    0,  1,    0, 0, 0, 1);
    add_step(REQ_WRITE, -1024, -1024,  1023,  1023, 255,  255,  1,    0, 0, 0, 1);
    add_step(REQ_WRITE,  1023,  1023, -1024, -1024,   0,    0,  1,    0, 0, 0, 1);
    add_step(REQ_READ,      0,     0,     0,     0,   0,    0,  1,  255, 1, 0, 0);
    add_step(REQ_READ,     31,    31,     0,     0, 255,  255,  1,    0, 0, 0, 0);
    // reads off the map give -1, flagged occupied
    add_step(REQ_READ,     -1,     0,     0,     0,   0,    0,  1,   -1, 1, 0, 0);
    add_step(REQ_READ,   1023, -1024,     0,     0,   0,    0,  1,   -1, 1, 0, 0);
    add_step(REQ_READ,      2,     0,     0,     0,   0,    0,  0,    0, 0, 0, 0);
    add_step(REQ_COUNT,     0,     0,     2,     0,   0,  255,  0,    0, 0, 0, 0);
    add_step(REQ_COUNT,     0,     0,     2,     0,   0,    7,  0,    0, 0, 0, 0);
    // left past right, then top below bottom: the far edge wins
    add_step(REQ_COUNT,     2,     0,     0,     0,   0,  255,  0,    0, 0, 0, 0);
    add_step(REQ_COUNT,     0,  1023,     1,     0,   0,  255,  0,    0, 0, 0, 0);
    // edges clamped into the map from below and from above
    add_step(REQ_COUNT, -1024,    -5,     2, -1024,   0,  255,  0,    0, 0, 0, 0);
    add_step(REQ_COUNT,  1023,  1023,  1023,  1023,   0,    0,  0,    0, 0, 0, 0);
    // unknown request: nothing changes, all-zero response
    add_step(REQ_NONE,   1023, -1024,  1023, -1024, 255,  255,  1,    0, 0, 0, 0);

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_steps[i])
      issue_req(dir_steps[i].rq, dir_steps[i].typed, dir_steps[i].want, 1'b0);

    // Random phases, one map size each.
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      set_map_size(ph_w[ph], ph_h[ph]);
      gap_max = ph_gap[ph];
      w       = used_dim(ph_w[ph], MAX_COLS_DEF);
      h       = used_dim(ph_h[ph], MAX_ROWS_DEF);

      // Every entry the new shape can address must hold a known value first.
      for (ix = 0; ix < w * h; ix++) begin
        if (!tile_loaded[ix]) begin
          rq.kind      = REQ_WRITE;
          rq.col       = COORD_W'(ix % w);
          rq.row       = COORD_W'(ix / w);
          rq.col_end   = pick_coord(w);
          rq.row_end   = pick_coord(h);
          rq.wr_val    = pick_tile_val();
          rq.match_val = pick_tile_val();
          issue_req(rq, 1'b0, no_resp, 1'b0);
        end
      end

      for (k = 0; k < PHASE_ITEMS; k++) begin
        p = $urandom_range(0, 19);
        if (p < 6) begin
          rq.kind = REQ_READ;
        end else if (p < 12) begin
          rq.kind = REQ_WRITE;
        end else if (p < 19) begin
          rq.kind = REQ_COUNT;
        end else begin
          rq.kind = REQ_NONE;
        end
        rq.col       = pick_coord(w);
        rq.row       = pick_coord(h);
        rq.col_end   = pick_coord(w);
        rq.row_end   = pick_coord(h);
        rq.wr_val    = pick_tile_val();
        rq.match_val = pick_tile_val();
        // long result stall while requests keep coming: input must back up
        if (ph == 3 && k == 30) hold_off_req = 1'b1;
        // once mid-phase, let the block run completely dry before going on
        issue_req(rq, 1'b0, no_resp, ph == 4 && k == 45);
      end
    end

    in_valid <= 1'b0;
    while (tile_resp_q.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (bad_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/tmsrc_pkg.sv
design/tmsrc_clamp.sv
design/tile_map_store_region_count.sv
tb/testbench.sv
